>>> hdl/accel_fall_detector_core_defines.svh
// Assertion macros shared by the fall detector RTL.
`ifndef ACCEL_FALL_DETECTOR_CORE_DEFINES_SVH
`define ACCEL_FALL_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge.
`define AFD_ASSERT_NOW(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("afd check failed");

// Next-cycle implication, checked on every rising clock edge.
`define AFD_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("afd check failed");

`endif

>>> hdl/afd_pkg.sv
// Shared types, codes and constants of the fall detector.
`default_nettype none

package afd_pkg;

  localparam int ACC_W  = 16;
  localparam int TIME_W = 40;
  localparam int THR_W  = 16;
  localparam int DUR_W  = 32;
  localparam int SQ_W   = 31;
  localparam int MAG_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_FREE      = 2'd1;
  localparam logic [1:0] PH_IMPACT    = 2'd2;
  localparam logic [1:0] PH_CONFIRMED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FREE_FALL_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMPACT_THR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_THR     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_DUR     = 2'd3;

  localparam logic [THR_W-1:0] FREE_FALL_THR_RESET = 16'd6554;
  localparam logic [THR_W-1:0] IMPACT_THR_RESET    = 16'd32768;
  localparam logic [THR_W-1:0] STILL_THR_RESET     = 16'd19661;
  localparam logic [DUR_W-1:0] STILL_DUR_RESET     = 32'd2000000;

  localparam logic [MAG_W-1:0] FREE_FALL_SQ_RESET =
    MAG_W'(FREE_FALL_THR_RESET) * MAG_W'(FREE_FALL_THR_RESET);
  localparam logic [MAG_W-1:0] IMPACT_SQ_RESET =
    MAG_W'(IMPACT_THR_RESET) * MAG_W'(IMPACT_THR_RESET);
  localparam logic [MAG_W-1:0] STILL_SQ_RESET =
    MAG_W'(STILL_THR_RESET) * MAG_W'(STILL_THR_RESET);

  typedef struct packed {
    logic [MAG_W-1:0] free_fall_sq;
    logic [MAG_W-1:0] impact_sq;
    logic [MAG_W-1:0] still_sq;
    logic [DUR_W-1:0] still_duration_us;
  } afd_cfg_t;

  typedef struct packed {
    logic              kind;
    logic [SQ_W-1:0]   sq_x;
    logic [SQ_W-1:0]   sq_y;
    logic [SQ_W-1:0]   sq_z;
    logic [TIME_W-1:0] time_us;
  } afd_mag_t;

endpackage

`default_nettype wire

>>> hdl/afd_stream_if.sv
// Sample and result channel interfaces of the fall detector.
`default_nettype none

interface afd_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [afd_pkg::ACC_W-1:0]    accel_x;
  logic signed [afd_pkg::ACC_W-1:0]    accel_y;
  logic signed [afd_pkg::ACC_W-1:0]    accel_z;
  logic        [afd_pkg::TIME_W-1:0]   time_us;

  modport source (output valid, kind, accel_x, accel_y, accel_z, time_us, input ready);
  modport sink   (input valid, kind, accel_x, accel_y, accel_z, time_us, output ready);
endinterface

interface afd_out_if;
  logic       valid;
  logic       ready;
  logic       fall_alarm;
  logic [1:0] phase;

  modport source (output valid, fall_alarm, phase, input ready);
  modport sink   (input valid, fall_alarm, phase, output ready);
endinterface

`default_nettype wire

>>> hdl/afd_cfg.sv
// Configuration registers; thresholds are kept squared.
`default_nettype none

module afd_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [afd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [afd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output afd_pkg::afd_cfg_t                     cfg
);

  logic [afd_pkg::MAG_W-1:0] wr_sq;

  assign wr_sq = afd_pkg::MAG_W'(cfg_wdata[afd_pkg::THR_W-1:0]) *
                 afd_pkg::MAG_W'(cfg_wdata[afd_pkg::THR_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.free_fall_sq      <= afd_pkg::FREE_FALL_SQ_RESET;
      cfg.impact_sq         <= afd_pkg::IMPACT_SQ_RESET;
      cfg.still_sq          <= afd_pkg::STILL_SQ_RESET;
      cfg.still_duration_us <= afd_pkg::STILL_DUR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        afd_pkg::REG_FREE_FALL_THR: cfg.free_fall_sq      <= wr_sq;
        afd_pkg::REG_IMPACT_THR:    cfg.impact_sq         <= wr_sq;
        afd_pkg::REG_STILL_THR:     cfg.still_sq          <= wr_sq;
        afd_pkg::REG_STILL_DUR:     cfg.still_duration_us <= cfg_wdata[afd_pkg::DUR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/afd_mag.sv
// Input register and per-axis squaring.
`default_nettype none

module afd_mag (
  input  wire logic         clk,
  input  wire logic         rst,
  afd_in_if.sink            sample_in,
  output logic              mag_valid,
  input  wire logic         mag_ready,
  output afd_pkg::afd_mag_t mag
);

  logic                                s1_valid;
  logic                                s1_kind;
  logic signed [afd_pkg::ACC_W-1:0]    s1_x;
  logic signed [afd_pkg::ACC_W-1:0]    s1_y;
  logic signed [afd_pkg::ACC_W-1:0]    s1_z;
  logic        [afd_pkg::TIME_W-1:0]   s1_time;
  logic signed [afd_pkg::MAG_W-1:0]    p_x;
  logic signed [afd_pkg::MAG_W-1:0]    p_y;
  logic signed [afd_pkg::MAG_W-1:0]    p_z;

  assign mag_valid       = s1_valid;
  assign sample_in.ready = !s1_valid || mag_ready;

  assign p_x = afd_pkg::MAG_W'(s1_x) * afd_pkg::MAG_W'(s1_x);
  assign p_y = afd_pkg::MAG_W'(s1_y) * afd_pkg::MAG_W'(s1_y);
  assign p_z = afd_pkg::MAG_W'(s1_z) * afd_pkg::MAG_W'(s1_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_in.ready) begin
      s1_valid <= sample_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_in.ready && sample_in.valid) begin
      s1_kind <= sample_in.kind;
      s1_x    <= sample_in.accel_x;
      s1_y    <= sample_in.accel_y;
      s1_z    <= sample_in.accel_z;
      s1_time <= sample_in.time_us;
    end
  end

  always_comb begin
    mag.kind    = s1_kind;
    mag.sq_x    = p_x[afd_pkg::SQ_W-1:0];
    mag.sq_y    = p_y[afd_pkg::SQ_W-1:0];
    mag.sq_z    = p_z[afd_pkg::SQ_W-1:0];
    mag.time_us = s1_time;
  end

endmodule

`default_nettype wire

>>> hdl/afd_phase.sv
// Phase machine, impact timestamp and result register.
`default_nettype none

module afd_phase (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire afd_pkg::afd_cfg_t cfg,
  input  wire logic              mag_valid,
  output logic                   mag_ready,
  input  wire afd_pkg::afd_mag_t mag,
  afd_out_if.source              result_out
);

  logic [1:0]                    fall_phase;
  logic [1:0]                    fall_phase_next;
  logic [afd_pkg::TIME_W-1:0]    impact_time;
  logic [afd_pkg::TIME_W-1:0]    impact_time_next;
  logic                          alarm_next;
  logic [afd_pkg::MAG_W-1:0]     mag2;
  logic [afd_pkg::TIME_W-1:0]    elapsed;
  logic                          beat;

  assign mag_ready = !result_out.valid || result_out.ready;
  assign beat      = mag_valid && mag_ready;

  assign mag2 = afd_pkg::MAG_W'(mag.sq_x) + afd_pkg::MAG_W'(mag.sq_y) +
                afd_pkg::MAG_W'(mag.sq_z);
  assign elapsed = mag.time_us - impact_time;

  always_comb begin
    fall_phase_next  = fall_phase;
    impact_time_next = impact_time;
    alarm_next       = 1'b0;
    if (mag.kind) begin
      fall_phase_next  = afd_pkg::PH_IDLE;
      impact_time_next = '0;
    end else begin
      unique case (fall_phase)
        afd_pkg::PH_IDLE: begin
          if (mag2 < cfg.free_fall_sq) fall_phase_next = afd_pkg::PH_FREE;
        end
        afd_pkg::PH_FREE: begin
          if (mag2 > cfg.impact_sq) begin
            fall_phase_next  = afd_pkg::PH_IMPACT;
            impact_time_next = mag.time_us;
          end
        end
        afd_pkg::PH_IMPACT: begin
          if (mag2 < cfg.still_sq) begin
            if (elapsed > afd_pkg::TIME_W'(cfg.still_duration_us)) begin
              fall_phase_next = afd_pkg::PH_CONFIRMED;
              alarm_next      = 1'b1;
            end
          end else begin
            fall_phase_next = afd_pkg::PH_IDLE;
          end
        end
        afd_pkg::PH_CONFIRMED: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fall_phase       <= afd_pkg::PH_IDLE;
      impact_time      <= '0;
      result_out.valid <= 1'b0;
    end else begin
      if (mag_ready) result_out.valid <= mag_valid;
      if (beat) begin
        fall_phase  <= fall_phase_next;
        impact_time <= impact_time_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      result_out.fall_alarm <= alarm_next;
      result_out.phase      <= fall_phase_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/accel_fall_detector_core.sv
// Top level of the accelerometer fall detector.
//
// sample_in carries one beat per sample: kind (0 sample, 1 clear), three
// signed 16-bit axis counts at 16384 per g and a 40-bit microsecond stamp.
// result_out returns exactly one beat per sample: fall_alarm and phase
// (0 idle, 1 free fall, 2 impact, 3 confirmed). A beat moves when valid
// and ready are both high.
// An accepted sample passes the input register, then per-axis squaring,
// the magnitude sum, threshold compares and phase update into the result
// register. One sample is accepted every cycle while the receiver holds
// ready; the two registers, each refilled as it empties, set that rate.
// Thresholds are written on the cfg port and stored squared.
// Reset is synchronous: phase goes idle, the impact stamp clears, the
// registers take their defaults and the pipeline empties.
// When the receiver stalls, the result register holds and the input
// register behind it fills; sample_in.ready drops only once both are full.
`default_nettype none
`include "accel_fall_detector_core_defines.svh"

module accel_fall_detector_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  afd_in_if.sink                                sample_in,
  afd_out_if.source                             result_out,
  input  wire logic                             cfg_we,
  input  wire logic [afd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [afd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  afd_pkg::afd_cfg_t cfg;
  afd_pkg::afd_mag_t mag;
  logic              mag_valid;
  logic              mag_ready;

  afd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  afd_mag u_mag (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_in),
    .mag_valid (mag_valid),
    .mag_ready (mag_ready),
    .mag       (mag)
  );

  afd_phase u_phase (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .mag_valid  (mag_valid),
    .mag_ready  (mag_ready),
    .mag        (mag),
    .result_out (result_out)
  );

  `AFD_ASSERT_NOW(a_alarm_confirmed, clk, rst, result_out.valid && result_out.fall_alarm, result_out.phase == afd_pkg::PH_CONFIRMED)
  `AFD_ASSERT_NEXT(a_alarm_once, clk, rst, result_out.valid && result_out.ready && result_out.fall_alarm, !(result_out.valid && result_out.fall_alarm))
  `AFD_ASSERT_NOW(a_pipe_open, clk, rst, !result_out.valid, mag_ready)
  `AFD_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !result_out.valid && !mag_valid)

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for accel_fall_detector_core: phase machine prediction and random beats.
`timescale 1ns / 100ps

module tb;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;
  localparam int   CYCLE_LIMIT = 400000;
  localparam int   IDLE_PCT    = 27;

  typedef struct {
    logic                               kind;
    logic signed [afd_pkg::ACC_W-1:0]   x;
    logic signed [afd_pkg::ACC_W-1:0]   y;
    logic signed [afd_pkg::ACC_W-1:0]   z;
    logic        [afd_pkg::TIME_W-1:0]  t;
  } sample_t;

  typedef struct {
    logic       alarm;
    logic [1:0] phase;
  } verdict_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [afd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [afd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  afd_in_if  sample_in ();
  afd_out_if result_out ();

  accel_fall_detector_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_in),
    .result_out (result_out),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  sample_t  pending_samples[$];
  verdict_t expected_verdicts[$];
  sample_t  on_bus;
  logic     steady;
  int       errors;
  int       queued;
  int       cycles;

  logic [afd_pkg::THR_W-1:0]  free_fall_thr = afd_pkg::FREE_FALL_THR_RESET;
  logic [afd_pkg::THR_W-1:0]  impact_thr    = afd_pkg::IMPACT_THR_RESET;
  logic [afd_pkg::THR_W-1:0]  still_thr     = afd_pkg::STILL_THR_RESET;
  logic [afd_pkg::DUR_W-1:0]  still_dur     = afd_pkg::STILL_DUR_RESET;
  logic [1:0]                 fall_phase_q  = afd_pkg::PH_IDLE;
  logic [afd_pkg::TIME_W-1:0] impact_stamp  = '0;
  logic [afd_pkg::TIME_W-1:0] clock_us;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("accel_fall_detector_core regression: fail");
      $finish;
    end
  end

  function automatic longint unsigned axis_sq(logic signed [afd_pkg::ACC_W-1:0] a);
    longint signed w;
    w = a;
    return longint'(w * w);
  endfunction

  function automatic longint unsigned thr_sq(logic [afd_pkg::THR_W-1:0] thr);
    longint unsigned w;
    w = thr;
    return w * w;
  endfunction

  task automatic predict_verdict(input sample_t s);
    verdict_t                   v;
    longint unsigned            mag2;
    logic [afd_pkg::TIME_W-1:0] span;
    v.alarm = 1'b0;
    if (s.kind == KIND_CLEAR) begin
      fall_phase_q = afd_pkg::PH_IDLE;
      impact_stamp = '0;
    end else begin
      mag2 = axis_sq(s.x) + axis_sq(s.y) + axis_sq(s.z);
      unique case (fall_phase_q)
        afd_pkg::PH_IDLE: begin
          if (mag2 < thr_sq(free_fall_thr)) fall_phase_q = afd_pkg::PH_FREE;
        end
        afd_pkg::PH_FREE: begin
          if (mag2 > thr_sq(impact_thr)) begin
            fall_phase_q = afd_pkg::PH_IMPACT;
            impact_stamp = s.t;
          end
        end
        afd_pkg::PH_IMPACT: begin
          if (mag2 < thr_sq(still_thr)) begin
            span = s.t - impact_stamp;
            if (span > {8'd0, still_dur}) begin
              fall_phase_q = afd_pkg::PH_CONFIRMED;
              v.alarm = 1'b1;
            end
          end else begin
            fall_phase_q = afd_pkg::PH_IDLE;
          end
        end
        default: ;
      endcase
    end
    v.phase = fall_phase_q;
    expected_verdicts.push_back(v);
  endtask

  always @(posedge clk) begin : drive_samples
    if (rst) begin
      sample_in.valid <= 1'b0;
    end else begin
      if (sample_in.valid && sample_in.ready) predict_verdict(on_bus);
      if (!sample_in.valid || sample_in.ready) begin
        if (pending_samples.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          on_bus = pending_samples.pop_front();
          sample_in.valid   <= 1'b1;
          sample_in.kind    <= on_bus.kind;
          sample_in.accel_x <= on_bus.x;
          sample_in.accel_y <= on_bus.y;
          sample_in.accel_z <= on_bus.z;
          sample_in.time_us <= on_bus.t;
        end else begin
          sample_in.valid <= 1'b0;
        end
      end
    end
  end

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst) begin
      result_out.ready <= 1'b0;
    end else begin
      if (result_out.valid && result_out.ready) begin
        if (expected_verdicts.size() == 0) begin
          flag_error("result beat with nothing expected");
        end else begin
          want = expected_verdicts.pop_front();
          if (result_out.fall_alarm !== want.alarm)
            flag_error($sformatf("fall_alarm got %b want %b",
                                 result_out.fall_alarm, want.alarm));
          if (result_out.phase !== want.phase)
            flag_error($sformatf("phase got %0d want %0d", result_out.phase, want.phase));
        end
      end
      result_out.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic push_sample(input logic kind, input int x, input int y, input int z,
                             input logic [afd_pkg::TIME_W-1:0] t);
    sample_t s;
    s.kind = kind;
    s.x = afd_pkg::ACC_W'(x);
    s.y = afd_pkg::ACC_W'(y);
    s.z = afd_pkg::ACC_W'(z);
    s.t = t;
    pending_samples.push_back(s);
    queued++;
  endtask

  function automatic logic [afd_pkg::TIME_W-1:0] rand_stamp();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[afd_pkg::TIME_W-1:0];
  endfunction

  function automatic int quiet_axis(logic [afd_pkg::THR_W-1:0] thr);
    int v;
    v = $urandom_range(thr / 2);
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic int loud_axis();
    int v;
    v = $urandom_range(32768, 20000);
    if (v == 32768) return -32768;
    return $urandom_range(1) ? -v : v;
  endfunction

  task automatic push_noise();
    push_sample($urandom_range(15) == 0, $urandom, $urandom, $urandom, rand_stamp());
  endtask

  task automatic push_quiet(input logic [afd_pkg::THR_W-1:0] thr);
    push_sample(KIND_SAMPLE, quiet_axis(thr), quiet_axis(thr), quiet_axis(thr), clock_us);
  endtask

  task automatic queue_fall_story();
    logic [afd_pkg::TIME_W-1:0] step;
    repeat ($urandom_range(2)) push_noise();
    push_quiet(free_fall_thr);
    if ($urandom_range(2) == 0) push_quiet(free_fall_thr);
    clock_us += afd_pkg::TIME_W'($urandom_range(1000));
    push_sample(KIND_SAMPLE, loud_axis(), loud_axis(), loud_axis(), clock_us);
    repeat ($urandom_range(5, 1)) begin
      step = afd_pkg::TIME_W'(still_dur >> $urandom_range(2)) +
             afd_pkg::TIME_W'($urandom_range(2));
      clock_us += step;
      if ($urandom_range(9) == 0)
        push_sample(KIND_SAMPLE, loud_axis(), loud_axis(), loud_axis(), clock_us);
      else
        push_quiet(still_thr);
    end
    repeat ($urandom_range(2)) push_noise();
    if ($urandom_range(3) != 0) push_sample(KIND_CLEAR, $urandom, $urandom, $urandom, rand_stamp());
  endtask

  task automatic run_random(input int target);
    int goal;
    goal = queued + target;
    clock_us = rand_stamp();
    while (queued < goal) begin
      if ($urandom_range(3) != 0) queue_fall_story();
      else repeat ($urandom_range(4, 1)) push_noise();
    end
  endtask

  task automatic settle();
    while (pending_samples.size() != 0 || sample_in.valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [afd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [afd_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    unique case (idx)
      afd_pkg::REG_FREE_FALL_THR: free_fall_thr = data[afd_pkg::THR_W-1:0];
      afd_pkg::REG_IMPACT_THR:    impact_thr    = data[afd_pkg::THR_W-1:0];
      afd_pkg::REG_STILL_THR:     still_thr     = data[afd_pkg::THR_W-1:0];
      afd_pkg::REG_STILL_DUR:     still_dur     = data[afd_pkg::DUR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_detector(input int unsigned ff, input int unsigned imp,
                                  input int unsigned still, input int unsigned dur);
    settle();
    write_reg(afd_pkg::REG_FREE_FALL_THR, ff);
    write_reg(afd_pkg::REG_IMPACT_THR, imp);
    write_reg(afd_pkg::REG_STILL_THR, still);
    write_reg(afd_pkg::REG_STILL_DUR, dur);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    steady = 1'b0;
    errors = 0;
    queued = 0;
    cycles = 0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    sample_in.valid = 1'b0;
    sample_in.kind = KIND_SAMPLE;
    sample_in.accel_x = '0;
    sample_in.accel_y = '0;
    sample_in.accel_z = '0;
    sample_in.time_us = '0;
    result_out.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_sample(KIND_SAMPLE, 0, 0, 0, 40'd0);
    push_sample(KIND_SAMPLE, -32768, 0, 0, 40'd1);
    push_sample(KIND_SAMPLE, -32768, 1, 0, 40'hFF_FFF0_BDC0);
    push_sample(KIND_SAMPLE, 0, 0, 16384, 40'd1000000);
    push_sample(KIND_SAMPLE, 0, 0, 16384, 40'd1000001);
    push_sample(KIND_SAMPLE, 32767, 32767, 32767, 40'hFF_FFFF_FFFF);
    push_sample(KIND_CLEAR, 32767, -32768, -1, 40'hFF_FFFF_FFFF);
    push_sample(KIND_SAMPLE, 6554, 0, 0, 40'd2);
    push_sample(KIND_SAMPLE, 6553, 0, 0, 40'd3);
    push_sample(KIND_SAMPLE, 32767, 32767, 32767, 40'd100);
    push_sample(KIND_SAMPLE, 19661, 0, 0, 40'd200);
    push_sample(KIND_SAMPLE, 0, -6553, 0, 40'd300);
    push_sample(KIND_SAMPLE, 32767, -32768, -32768, 40'd5000);
    push_sample(KIND_SAMPLE, 0, -100, 100, 40'd4000);
    push_sample(KIND_CLEAR, 0, 0, 0, 40'd0);
    push_sample(KIND_CLEAR, -1, -1, -1, 40'hFF_FFFF_FFFF);
    push_sample(KIND_SAMPLE, 1, -1, 1, 40'd10);
    push_sample(KIND_CLEAR, 5, 5, 5, 40'd11);
    push_sample(KIND_SAMPLE, 0, 0, 0, 40'd20);
    push_sample(KIND_SAMPLE, -32768, -32768, -32768, 40'd30);
    push_sample(KIND_SAMPLE, -32768, 0, 0, 40'd40);
    push_sample(KIND_SAMPLE, 0, 0, 0, 40'd50);
    push_sample(KIND_SAMPLE, 30000, 0, 0, 40'd60);
    push_sample(KIND_CLEAR, 0, 0, 0, 40'd70);

    program_detector($urandom_range(12000, 2000), $urandom_range(40000, 20000),
                     $urandom_range(30000, 10000), $urandom_range(5000));
    run_random(170);
    program_detector(32'hFFFF, 0, 32'hFFFF, 0);
    run_random(170);
    program_detector(0, 32'hFFFF, 0, 32'hFFFF_FFFF);
    run_random(60);
    program_detector($urandom_range(12000, 2000), $urandom_range(40000, 20000),
                     $urandom_range(30000, 10000), 32'hFFFF_FFFF);
    run_random(170);
    program_detector($urandom_range(65535), $urandom_range(65535),
                     $urandom_range(65535), $urandom_range(20000));
    steady <= 1'b1;
    run_random(150);
    settle();
    steady <= 1'b0;
    run_random(100);

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("accel_fall_detector_core regression: pass");
    end else begin
      $display("accel_fall_detector_core regression: fail");
    end
    $finish;
  end

endmodule

>>> accel_fall_detector_core.f
+incdir+hdl
hdl/afd_pkg.sv
hdl/afd_stream_if.sv
hdl/afd_cfg.sv
hdl/afd_mag.sv
hdl/afd_phase.sv
hdl/accel_fall_detector_core.sv
sim/tb.sv
